// ===== src/rsc_pkg.sv =====
// Shared types and constants for the RPN stack calculator.
package rsc_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_ADD  = 2'd2,
    CMD_MUL  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_POP_EMPTY    = 2'd1,
    ST_FEW_OPERANDS = 2'd2,
    ST_FULL         = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_WAIT,
    S_MUL,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    capture;
    status_t status;
    logic    push;
    logic    read_below;
    logic    pop_load;
    logic    add_load;
    logic    mul_start;
    logic    mul_load;
    logic    load_out;
  } dp_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic few;
    logic full;
    cmd_t cmd;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== src/rpn_stack_calculator_top.sv =====
// RPN stack calculator top level.
//
// Input channel: cmd (push, pop, add, multiply) and push_value, taken on a
// rising edge with in_valid high and in_stall low. Output channel: one word
// per command with top_value, stack_empty, stack_count and status, taken on
// a rising edge with out_valid high and out_stall low.
//
// Values are signed Q16.16; add and multiply saturate, multiply rounds to
// nearest. A failing command leaves the stack as it was and reports status.
// The top entry lives in a register, the rest in a stack RAM.
//
// An error result goes straight to the output register. Push first loads
// the top register and pop and add first read the RAM; multiply reads the
// second operand from the RAM, then multiplies, then rounds. One command is
// in flight at a time, and a new command is taken as soon as the previous
// result sits in the output register, even if the receiver stalls it. A
// stalled output holds its word and the next result waits in the sequencer.
// Reset empties the stack and drops any pending output; no clearing pass.
module rpn_stack_calculator_top import rsc_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               cmd,
  input  logic signed [DATA_W-1:0] push_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] top_value,
  output logic                     stack_empty,
  output logic [COUNT_W-1:0]       stack_count,
  output logic [1:0]               status
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  rsc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .cmd     (cmd),
    .in_stall(in_stall),
    .stat    (stat),
    .ctrl    (ctrl)
  );

  rsc_datapath #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .push_value (push_value),
    .ctrl       (ctrl),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .top_value  (top_value),
    .stack_empty(stack_empty),
    .stack_count(stack_count),
    .status     (status)
  );

endmodule

// ===== src/rsc_ram.sv =====
// Generic simple dual-port RAM with registered read.
module rsc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/rsc_ctrl.sv =====
// Command sequencer for the RPN stack calculator.
module rsc_ctrl import rsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] cmd,
  output logic       in_stall,
  input  dp_stat_t   stat,
  output dp_ctrl_t   ctrl
);

  state_t  state;
  state_t  state_next;
  status_t err_code;
  cmd_t    in_cmd;

  assign in_cmd = cmd_t'(cmd);

  always_comb begin
    priority if (in_cmd == CMD_PUSH && stat.full) begin
      err_code = ST_FULL;
    end else if (in_cmd == CMD_POP && stat.empty) begin
      err_code = ST_POP_EMPTY;
    end else if ((in_cmd == CMD_ADD || in_cmd == CMD_MUL) && stat.few) begin
      err_code = ST_FEW_OPERANDS;
    end else begin
      err_code = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (err_code != ST_OK) begin
            state_next = S_OUT;
          end else if (in_cmd == CMD_PUSH) begin
            state_next = S_PUSH;
          end else begin
            state_next = S_WAIT;
          end
        end
      end
      S_PUSH: state_next = S_OUT;
      S_WAIT: state_next = (stat.cmd == CMD_MUL) ? S_MUL : S_OUT;
      S_MUL:  state_next = S_OUT;
      S_OUT: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl        = '0;
    ctrl.status = ST_OK;
    in_stall    = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctrl.capture    = 1'b1;
          ctrl.status     = err_code;
          ctrl.read_below = (err_code == ST_OK) && (in_cmd != CMD_PUSH);
        end
      end
      S_PUSH: ctrl.push = 1'b1;
      S_WAIT: begin
        unique case (stat.cmd)
          CMD_POP:  ctrl.pop_load  = 1'b1;
          CMD_ADD:  ctrl.add_load  = 1'b1;
          CMD_MUL:  ctrl.mul_start = 1'b1;
          default:  ctrl.pop_load  = 1'b0;
        endcase
      end
      S_MUL: ctrl.mul_load = 1'b1;
      S_OUT: ctrl.load_out = stat.out_free;
      default: in_stall = 1'b1;
    endcase
  end

endmodule

// ===== src/rsc_datapath.sv =====
// Stack datapath: top register, stack RAM, saturating add and multiply, result register.
module rsc_datapath import rsc_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [1:0]               cmd,
  input  logic signed [DATA_W-1:0] push_value,
  input  dp_ctrl_t                 ctrl,
  output dp_stat_t                 stat,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] top_value,
  output logic                     stack_empty,
  output logic [COUNT_W-1:0]       stack_count,
  output logic [1:0]               status
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic [CW-1:0]              count;
  logic [CW-1:0]              count_m1;
  logic [CW-1:0]              count_m2;
  logic signed [DATA_W-1:0]   top;
  logic signed [DATA_W-1:0]   val;
  cmd_t                       cmd_q;
  status_t                    stat_q;
  logic signed [2*DATA_W-1:0] prod;
  logic [DATA_W-1:0]          rd_data;
  logic signed [DATA_W-1:0]   below;
  logic signed [DATA_W:0]     sum;
  logic signed [DATA_W-1:0]   sum_sat;
  logic signed [2*DATA_W-1:0] prod_rnd;
  logic signed [DATA_W-1:0]   prod_sat;
  logic [CW+COUNT_W-1:0]      count_ext;

  assign count_m1 = count - CW'(1);
  assign count_m2 = count - CW'(2);
  assign below    = $signed(rd_data);

  rsc_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ctrl.push && (count != '0)),
    .waddr(count_m1[AW-1:0]),
    .wdata(top),
    .re   (ctrl.read_below),
    .raddr(count_m2[AW-1:0]),
    .rdata(rd_data)
  );

  // saturating Q16.16 add
  always_comb begin
    sum = {top[DATA_W-1], top} + {below[DATA_W-1], below};
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      sum_sat = sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sum_sat = sum[DATA_W-1:0];
    end
  end

  // round to nearest (ties up), then saturate
  always_comb begin
    prod_rnd = prod + 64'sd32768;
    if (prod_rnd[2*DATA_W-1:DATA_W+15] != '0 && prod_rnd[2*DATA_W-1:DATA_W+15] != '1) begin
      prod_sat = prod_rnd[2*DATA_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                      : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      prod_sat = prod_rnd[DATA_W+15:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.push) begin
      count <= count + CW'(1);
    end else if (ctrl.pop_load || ctrl.add_load || ctrl.mul_load) begin
      count <= count_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_q  <= cmd_t'(cmd);
      val    <= push_value;
      stat_q <= ctrl.status;
    end
    if (ctrl.mul_start) begin
      prod <= (2*DATA_W)'(top) * (2*DATA_W)'(below);
    end
    if (ctrl.push) begin
      top <= val;
    end else if (ctrl.pop_load) begin
      top <= below;
    end else if (ctrl.add_load) begin
      top <= sum_sat;
    end else if (ctrl.mul_load) begin
      top <= prod_sat;
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      top_value   <= (count == '0) ? '0 : top;
      stack_empty <= (count == '0);
      stack_count <= count_ext[COUNT_W-1:0];
      status      <= stat_q;
    end
  end

  assign stat.empty    = (count == '0);
  assign stat.few      = (count < CW'(2));
  assign stat.full     = (count >= CW'(STACK_DEPTH));
  assign stat.cmd      = cmd_q;
  assign stat.out_free = !out_valid || !out_stall;

endmodule

// ===== tb/tb_rpn_stack_calculator_top.sv =====
// Testbench for rpn_stack_calculator_top: random command streams checked against a stack predictor.
`timescale 1ns / 1ps

module tb_rpn_stack_calculator_top;
  import rsc_pkg::*;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned RANDOM_WORDS = 1250;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct {
    cmd_t        op;
    logic [31:0] val;
    int unsigned gap;
    bit          drain;
  } cmd_word_t;

  typedef struct {
    logic [31:0]        top;
    logic               empty;
    logic [COUNT_W-1:0] count;
    status_t            status;
  } result_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] cmd = '0;
  logic signed [DATA_W-1:0] push_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DATA_W-1:0] top_value;
  logic stack_empty;
  logic [COUNT_W-1:0] stack_count;
  logic [1:0] status;

  cmd_word_t    cmd_words[$];
  result_word_t results_due[$];

  logic [31:0] stack_vals [STACK_DEPTH];
  int unsigned stack_depth = 0;

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit          rx_calm = 1'b0;
  bit          tx_calm = 1'b0;

  rpn_stack_calculator_top #(.STACK_DEPTH(STACK_DEPTH)) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .push_value (push_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .top_value  (top_value),
    .stack_empty(stack_empty),
    .stack_count(stack_count),
    .status     (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [31:0] sat32(input longint v);
    if (v > SAT_HI) return 32'h7FFF_FFFF;
    if (v < SAT_LO) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // mostly short idles, a few long ones, none during calm stretches
  function automatic int unsigned pick_idle(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_q();
    logic [31:0] picks [9];
    int unsigned r;
    picks = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
              32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_8000};
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 32'h7FFFF) - 32'h40000;
    if (r < 7) return $urandom();
    if (r < 8) return picks[$urandom_range(0, 8)];
    return $urandom_range(0, 32'h1FF_FFFF) - 32'h100_0000;
  endfunction

  task automatic stack_predict(input cmd_t op, input logic [31:0] val);
    result_word_t r;
    logic [31:0] a, b;
    longint p;
    r.status = ST_OK;
    case (op)
      CMD_PUSH: begin
        if (stack_depth >= STACK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          stack_vals[stack_depth] = val;
          stack_depth++;
        end
      end
      CMD_POP: begin
        if (stack_depth == 0) r.status = ST_POP_EMPTY;
        else stack_depth--;
      end
      default: begin
        if (stack_depth < 2) begin
          r.status = ST_FEW_OPERANDS;
        end else begin
          a = stack_vals[stack_depth-1];
          b = stack_vals[stack_depth-2];
          if (op == CMD_ADD) begin
            p = longint'($signed(a)) + longint'($signed(b));
          end else begin
            p = ((longint'($signed(a)) * longint'($signed(b))) + 64'sd32768) >>> 16;
          end
          stack_vals[stack_depth-2] = sat32(p);
          stack_depth--;
        end
      end
    endcase
    r.top = (stack_depth > 0) ? stack_vals[stack_depth-1] : 32'h0;
    r.empty = (stack_depth == 0);
    r.count = stack_depth[COUNT_W-1:0];
    results_due.push_back(r);
  endtask

  task automatic queue_word(input cmd_t op, input logic [31:0] val, input bit drain);
    cmd_word_t w;
    w.op = op;
    w.val = val;
    w.gap = pick_idle(tx_calm);
    w.drain = drain;
    cmd_words.push_back(w);
  endtask

  // driver
  always @(posedge clk) begin
    cmd_word_t w;
    bit take;
    bit present;
    if (rst) begin
      in_valid <= 1'b0;
      stack_depth = 0;
    end else begin
      take = in_valid && !in_stall;
      if (take) stack_predict(cmd_t'(cmd), push_value);
      present = 1'b0;
      if (in_valid && !take) begin
        present = 1'b1;
      end else if (cmd_words.size() > 0) begin
        if (cmd_words[0].gap > 0) begin
          cmd_words[0].gap = cmd_words[0].gap - 1;
        end else if (!cmd_words[0].drain || results_due.size() == 0) begin
          w = cmd_words.pop_front();
          cmd <= w.op;
          push_value <= w.val;
          present = 1'b1;
        end
      end
      in_valid <= present;
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    result_word_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_error("result word with nothing expected");
        end else begin
          want = results_due.pop_front();
          if (top_value !== want.top)
            report_error($sformatf("top_value %h, expected %h", top_value, want.top));
          if (stack_empty !== want.empty)
            report_error($sformatf("stack_empty %b, expected %b", stack_empty, want.empty));
          if (stack_count !== want.count)
            report_error($sformatf("stack_count %0d, expected %0d", stack_count, want.count));
          if (status !== want.status)
            report_error($sformatf("status %0d, expected %0d", status, want.status));
        end
      end
      if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_idle(rx_calm);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL rpn_stack_calculator_top");
      $finish;
    end
  end

  initial begin
    int unsigned depth_est;
    bit filling;
    int unsigned r;
    cmd_t op;

    // empty-stack errors, saturation both ways, rounding ties
    queue_word(CMD_POP, rand_q(), 1'b0);
    queue_word(CMD_ADD, rand_q(), 1'b0);
    queue_word(CMD_MUL, rand_q(), 1'b0);
    queue_word(CMD_PUSH, 32'h7FFF_FFFF, 1'b0);
    queue_word(CMD_ADD, rand_q(), 1'b0);
    queue_word(CMD_MUL, rand_q(), 1'b0);
    queue_word(CMD_PUSH, 32'h7FFF_FFFF, 1'b0);
    queue_word(CMD_ADD, rand_q(), 1'b0);
    queue_word(CMD_PUSH, 32'h8000_0000, 1'b0);
    queue_word(CMD_ADD, rand_q(), 1'b0);
    queue_word(CMD_PUSH, 32'h8000_0000, 1'b0);
    queue_word(CMD_PUSH, 32'h8000_0000, 1'b0);
    queue_word(CMD_ADD, rand_q(), 1'b0);
    queue_word(CMD_PUSH, 32'h8000_0000, 1'b0);
    queue_word(CMD_MUL, rand_q(), 1'b0);
    queue_word(CMD_POP, rand_q(), 1'b0);
    queue_word(CMD_POP, rand_q(), 1'b0);
    queue_word(CMD_PUSH, 32'h0000_8000, 1'b0);
    queue_word(CMD_PUSH, 32'h0000_0001, 1'b0);
    queue_word(CMD_MUL, rand_q(), 1'b0);
    queue_word(CMD_PUSH, 32'hFFFF_8000, 1'b0);
    queue_word(CMD_MUL, rand_q(), 1'b0);
    queue_word(CMD_PUSH, 32'h0000_0000, 1'b0);
    queue_word(CMD_POP, rand_q(), 1'b0);
    queue_word(CMD_POP, rand_q(), 1'b0);

    // random part: fill and drain phases so full and empty are hit often
    depth_est = 0;
    filling = 1'b1;
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      if ($urandom_range(0, 99) == 0) tx_calm = !tx_calm;
      if (depth_est >= STACK_DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
      else if (depth_est == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      else if ($urandom_range(0, 49) == 0) filling = !filling;
      r = $urandom_range(0, 99);
      if (filling) op = (r < 60) ? CMD_PUSH : (r < 75) ? CMD_POP : (r < 87) ? CMD_ADD : CMD_MUL;
      else op = (r < 15) ? CMD_PUSH : (r < 55) ? CMD_POP : (r < 75) ? CMD_ADD : CMD_MUL;
      case (op)
        CMD_PUSH: if (depth_est < STACK_DEPTH) depth_est++;
        CMD_POP:  if (depth_est > 0) depth_est--;
        default:  if (depth_est >= 2) depth_est--;
      endcase
      queue_word(op, rand_q(), (i % 250) == 0);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (cmd_words.size() != 0 || in_valid) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS rpn_stack_calculator_top");
    end else begin
      $display("FAIL rpn_stack_calculator_top");
    end
    $finish;
  end

endmodule

// ===== rpn_stack_calculator_top.f =====
src/rsc_pkg.sv
src/rsc_ram.sv
src/rsc_ctrl.sv
src/rsc_datapath.sv
src/rpn_stack_calculator_top.sv
tb/tb_rpn_stack_calculator_top.sv
